### hdl/json_object_member_splitter_defines.svh
// assertion macros for the json object member splitter
// no dependencies; included by the rtl files that carry assertions
`ifndef JSON_OBJECT_MEMBER_SPLITTER_DEFINES_SVH
`define JSON_OBJECT_MEMBER_SPLITTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define JSPLIT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsplit assertion failed");
`define JSPLIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsplit assertion failed");
`else
`define JSPLIT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define JSPLIT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/jsplit_pkg.sv
// shared types and constants for the json object member splitter
// no dependencies; imported by jsplit_core, json_object_member_splitter and the dv files
package jsplit_pkg;

   localparam int POSITION_BITS = 16;
   localparam int DEPTH_BITS    = 8;
   localparam int OFFSET_BITS   = 16;
   localparam int BYTE_BITS     = 8;
   localparam int KIND_BITS     = 2;
   localparam int RSP_DATA_BITS = 4 * OFFSET_BITS;

   typedef logic [BYTE_BITS-1:0]     byte_type;
   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [DEPTH_BITS-1:0]    depth_type;
   typedef logic [OFFSET_BITS-1:0]   offset_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_COMMA = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_START        = 4'd0,
      PH_NAME_LQUOT   = 4'd1,
      PH_NAME_FIRST   = 4'd2,
      PH_NAME         = 4'd3,
      PH_NAME_RQUOT   = 4'd4,
      PH_BEFORE_VALUE = 4'd5,
      PH_STR_FIRST    = 4'd6,
      PH_STR          = 4'd7,
      PH_STR_AFTER    = 4'd8,
      PH_NUM_INT      = 4'd9,
      PH_NUM_FRAC     = 4'd10,
      PH_NUM_EXP_SIGN = 4'd11,
      PH_NUM_EXP      = 4'd12,
      PH_OBJECT       = 4'd13,
      PH_ARRAY        = 4'd14,
      PH_AFTER_VALUE  = 4'd15
   } phase_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      offset_type name_begin;
      offset_type name_finish;
      offset_type value_begin;
      offset_type value_finish;
   } result_type;

   localparam byte_type CH_LBRACE    = 8'h7B;
   localparam byte_type CH_RBRACE    = 8'h7D;
   localparam byte_type CH_LBRACKET  = 8'h5B;
   localparam byte_type CH_RBRACKET  = 8'h5D;
   localparam byte_type CH_COLON     = 8'h3A;
   localparam byte_type CH_COMMA     = 8'h2C;
   localparam byte_type CH_MINUS     = 8'h2D;
   localparam byte_type CH_DOT       = 8'h2E;
   localparam byte_type CH_PLUS      = 8'h2B;
   localparam byte_type CH_BACKSLASH = 8'h5C;
   localparam byte_type CH_QUOTE     = 8'h22;
   localparam byte_type CH_SPACE     = 8'h20;
   localparam byte_type CH_LOWER_E   = 8'h65;
   localparam byte_type CH_UPPER_E   = 8'h45;
   localparam byte_type CH_ZERO      = 8'h30;
   localparam byte_type CH_NINE      = 8'h39;
   localparam byte_type CH_DEL       = 8'h7F;
   localparam byte_type CH_CTRL_END  = 8'h20;

endpackage

### hdl/jsplit_core.sv
// parse state, byte position and nesting depth with the per-byte transition
// depends on jsplit_pkg and json_object_member_splitter_defines.svh
`include "json_object_member_splitter_defines.svh"

module jsplit_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  jsplit_pkg::byte_type   data_byte,
   output jsplit_pkg::result_type result
);
   import jsplit_pkg::*;

   phase_type phase_ff, phase_in;
   pos_type   pos_ff, pos_in;
   depth_type depth_ff, depth_in;
   pos_type   nb_ff, nb_in, nf_ff, nf_in, vb_ff, vb_in, vf_ff, vf_in;

   logic      err;
   logic      rep;
   kind_type  kind;
   logic      digit;
   logic      name_bad;
   logic      depth_full;
   depth_type depth_dec;
   byte_type  opener;
   byte_type  closer;

   always_comb begin
      digit      = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      name_bad   = (data_byte < CH_CTRL_END) || (data_byte == CH_DEL) ||
                   (data_byte == CH_BACKSLASH);
      depth_full = &depth_ff;
      depth_dec  = (depth_ff != '0) ? depth_ff - depth_type'(1) : '0;
      opener     = (phase_ff == PH_OBJECT) ? CH_LBRACE : CH_LBRACKET;
      closer     = (phase_ff == PH_OBJECT) ? CH_RBRACE : CH_RBRACKET;
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      depth_in = depth_ff;
      nb_in    = nb_ff;
      nf_in    = nf_ff;
      vb_in    = vb_ff;
      vf_in    = vf_ff;
      err      = 1'b0;
      rep      = 1'b0;
      kind     = KIND_COMMA;
      result   = '0;
      if (step_en) begin
         pos_in = pos_ff + pos_type'(1);
         unique case (phase_ff) inside
            PH_START: begin
               if (data_byte == CH_LBRACE) phase_in = PH_NAME_LQUOT;
               else err = 1'b1;
            end
            PH_NAME_LQUOT: begin
               if (data_byte == CH_QUOTE) phase_in = PH_NAME_FIRST;
               else if (data_byte != CH_SPACE) err = 1'b1;
            end
            PH_NAME_FIRST, PH_NAME: begin
               if (phase_ff == PH_NAME_FIRST) begin
                  nb_in    = pos_ff;
                  phase_in = PH_NAME;
               end
               if (name_bad) begin
                  err = 1'b1;
               end else if (data_byte == CH_QUOTE) begin
                  nf_in    = pos_ff;
                  phase_in = PH_NAME_RQUOT;
               end
            end
            PH_NAME_RQUOT: begin
               if (data_byte == CH_COLON) phase_in = PH_BEFORE_VALUE;
               else err = 1'b1;
            end
            PH_BEFORE_VALUE: begin
               if (data_byte == CH_SPACE) begin
               end else if (data_byte == CH_QUOTE) begin
                  phase_in = PH_STR_FIRST;
               end else if (data_byte == CH_LBRACE || data_byte == CH_LBRACKET) begin
                  if (depth_full) begin
                     err = 1'b1;
                  end else begin
                     depth_in = depth_ff + depth_type'(1);
                     vb_in    = pos_ff;
                     phase_in = (data_byte == CH_LBRACE) ? PH_OBJECT : PH_ARRAY;
                  end
               end else if (data_byte == CH_MINUS || digit) begin
                  vb_in    = pos_ff;
                  phase_in = PH_NUM_INT;
               end else begin
                  err = 1'b1;
               end
            end
            PH_STR_FIRST, PH_STR: begin
               if (phase_ff == PH_STR_FIRST) begin
                  vb_in    = pos_ff;
                  phase_in = PH_STR;
               end
               if (data_byte == CH_QUOTE) begin
                  vf_in    = pos_ff;
                  phase_in = PH_STR_AFTER;
               end
            end
            PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP: begin
               if (digit) begin
               end else if (data_byte == CH_DOT && phase_ff == PH_NUM_INT) begin
                  phase_in = PH_NUM_FRAC;
               end else if ((data_byte == CH_LOWER_E || data_byte == CH_UPPER_E) &&
                            phase_ff != PH_NUM_EXP) begin
                  phase_in = PH_NUM_EXP_SIGN;
               end else begin
                  // number ends here
                  vf_in = pos_ff;
                  rep   = 1'b1;
                  if (data_byte == CH_COMMA) kind = KIND_COMMA;
                  else if (data_byte == CH_RBRACE) kind = KIND_CLOSE;
                  else err = 1'b1;
               end
            end
            PH_NUM_EXP_SIGN: begin
               if (data_byte == CH_PLUS || data_byte == CH_MINUS || digit)
                  phase_in = PH_NUM_EXP;
               else
                  err = 1'b1;
            end
            PH_OBJECT, PH_ARRAY: begin
               if (data_byte == opener) begin
                  if (depth_full) err = 1'b1;
                  else depth_in = depth_ff + depth_type'(1);
               end else if (data_byte == closer) begin
                  depth_in = depth_dec;
                  if (depth_dec == '0) begin
                     vf_in    = pos_ff;
                     phase_in = PH_AFTER_VALUE;
                  end
               end
            end
            PH_STR_AFTER, PH_AFTER_VALUE: begin
               if (data_byte == CH_COMMA) begin
                  rep  = 1'b1;
                  kind = KIND_COMMA;
               end else if (data_byte == CH_RBRACE) begin
                  rep  = 1'b1;
                  kind = KIND_CLOSE;
               end else if (data_byte != CH_SPACE) begin
                  err = 1'b1;
               end
            end
         endcase

         if (err) begin
            phase_in     = PH_START;
            depth_in     = '0;
            result.valid = 1'b1;
            result.kind  = KIND_ERROR;
         end else if (rep) begin
            phase_in            = (kind == KIND_COMMA) ? PH_NAME_LQUOT : PH_START;
            depth_in            = '0;
            result.valid        = 1'b1;
            result.kind         = kind;
            result.name_begin   = offset_type'(nb_in);
            result.name_finish  = offset_type'(nf_in);
            result.value_begin  = offset_type'(vb_in);
            result.value_finish = offset_type'(vf_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         depth_ff <= '0;
         nb_ff    <= '0;
         nf_ff    <= '0;
         vb_ff    <= '0;
         vf_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         depth_ff <= depth_in;
         nb_ff    <= nb_in;
         nf_ff    <= nf_in;
         vb_ff    <= vb_in;
         vf_ff    <= vf_in;
      end
   end

   `JSPLIT_ASSERT_IMP(a_depth_only_nested, clock, reset, depth_ff != '0, phase_ff == PH_OBJECT || phase_ff == PH_ARRAY)
   `JSPLIT_ASSERT_IMP(a_error_zero_offsets, clock, reset, result.valid && result.kind == KIND_ERROR, result.name_begin == '0 && result.value_finish == '0)
   `JSPLIT_ASSERT_NEXT(a_result_clears_depth, clock, reset, result.valid, depth_ff == '0 && (phase_ff == PH_START || phase_ff == PH_NAME_LQUOT))
   `JSPLIT_ASSERT_NEXT(a_pos_advances, clock, reset, step_en, pos_ff == pos_type'($past(pos_ff) + pos_type'(1)))
   `JSPLIT_ASSERT_IMP(a_no_result_idle, clock, reset, !step_en, !result.valid)

endmodule

### hdl/json_object_member_splitter.sv
// top level of the json object member splitter: input stage, parser, result stage
// depends on jsplit_pkg and jsplit_core
//
// Takes one byte of JSON object text per beat on req_ and gives one rsp_ beat
// each time a member ends (followed by a comma or the closing brace) or a
// syntax error is found; other bytes give no result. Sustained rate is one
// byte per clock while rsp_ beats are taken (a held result stalls req_); a
// byte's result, if any, is offered from the result register. The rate is set
// by the parse transition in jsplit_core, which sits between the input
// register and the result register. Offsets count bytes from reset and wrap at
// 2^16; after an error the parser waits for a new opening brace.

module json_object_member_splitter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [jsplit_pkg::BYTE_BITS-1:0]        req_tdata,  // [7:0] data_byte
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [15:0] name_begin, [31:16] name_finish, [47:32] value_begin, [63:48] value_finish
   output logic [jsplit_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic [jsplit_pkg::KIND_BITS-1:0]        rsp_tuser   // [1:0] result_kind
);
   import jsplit_pkg::*;

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   logic       advance;
   logic       step_en;

   always_comb begin
      advance     = !out_valid_ff || rsp_tready;
      step_en     = in_valid_ff && advance;
      req_tready  = !in_valid_ff || advance;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? res.valid : out_valid_ff;
   end

   jsplit_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .result    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {out_ff.value_finish, out_ff.value_begin,
                        out_ff.name_finish, out_ff.name_begin};

endmodule

### dv/json_object_member_splitter_checker.sv
// checker for the json object member splitter: predicts member reports from accepted bytes
// and compares them with result beats; depends on jsplit_pkg
module json_object_member_splitter_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [jsplit_pkg::BYTE_BITS-1:0]     req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [jsplit_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic [jsplit_pkg::KIND_BITS-1:0]     rsp_tuser,
   output int unsigned                        mismatches,
   output int unsigned                        results_due
);
   import jsplit_pkg::*;

   typedef struct packed {
      kind_type   kind;
      offset_type name_begin;
      offset_type name_finish;
      offset_type value_begin;
      offset_type value_finish;
   } member_report_type;

   localparam depth_type DEPTH_TOP = '1;

   phase_type         phase = PH_START;
   pos_type           position = '0;
   depth_type         depth = '0;
   offset_type        name_begin_q = '0;
   offset_type        name_finish_q = '0;
   offset_type        value_begin_q = '0;
   offset_type        value_finish_q = '0;
   member_report_type pending_members[$];
   int unsigned       fails = 0;

   function automatic bit is_digit(input byte_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void report_member(input kind_type kind);
      member_report_type r;
      r.kind = kind;
      if (kind == KIND_ERROR) begin
         r.name_begin   = '0;
         r.name_finish  = '0;
         r.value_begin  = '0;
         r.value_finish = '0;
         phase = PH_START;
      end else begin
         r.name_begin   = name_begin_q;
         r.name_finish  = name_finish_q;
         r.value_begin  = value_begin_q;
         r.value_finish = value_finish_q;
         phase = (kind == KIND_COMMA) ? PH_NAME_LQUOT : PH_START;
      end
      depth = '0;
      pending_members.push_back(r);
   endfunction

   function automatic bit name_char_bad(input byte_type c, input pos_type here);
      if (c < CH_CTRL_END || c == CH_DEL || c == CH_BACKSLASH) return 1'b1;
      if (c == CH_QUOTE) begin
         name_finish_q = offset_type'(here);
         phase = PH_NAME_RQUOT;
      end
      return 1'b0;
   endfunction

   function automatic void end_number(input byte_type c, input pos_type here);
      value_finish_q = offset_type'(here);
      if (c == CH_COMMA) report_member(KIND_COMMA);
      else if (c == CH_RBRACE) report_member(KIND_CLOSE);
      else report_member(KIND_ERROR);
   endfunction

   function automatic bit open_value(input phase_type inner_phase, input pos_type here);
      if (depth == DEPTH_TOP) return 1'b1;
      depth++;
      value_begin_q = offset_type'(here);
      phase = inner_phase;
      return 1'b0;
   endfunction

   function automatic void parse_byte(input byte_type c);
      pos_type  here;
      bit       fail;
      byte_type opener;
      byte_type closer;
      here = position;
      fail = 1'b0;
      position = position + 1'b1;
      case (phase)
         PH_START: begin
            if (c == CH_LBRACE) phase = PH_NAME_LQUOT;
            else fail = 1'b1;
         end
         PH_NAME_LQUOT: begin
            if (c == CH_QUOTE) phase = PH_NAME_FIRST;
            else if (c != CH_SPACE) fail = 1'b1;
         end
         PH_NAME_FIRST: begin
            name_begin_q = offset_type'(here);
            phase = PH_NAME;
            fail = name_char_bad(c, here);
         end
         PH_NAME: fail = name_char_bad(c, here);
         PH_NAME_RQUOT: begin
            if (c == CH_COLON) phase = PH_BEFORE_VALUE;
            else fail = 1'b1;
         end
         PH_BEFORE_VALUE: begin
            if (c == CH_SPACE) begin
            end else if (c == CH_QUOTE) begin
               phase = PH_STR_FIRST;
            end else if (c == CH_LBRACE) begin
               fail = open_value(PH_OBJECT, here);
            end else if (c == CH_LBRACKET) begin
               fail = open_value(PH_ARRAY, here);
            end else if (c == CH_MINUS || is_digit(c)) begin
               value_begin_q = offset_type'(here);
               phase = PH_NUM_INT;
            end else begin
               fail = 1'b1;
            end
         end
         PH_STR_FIRST: begin
            value_begin_q = offset_type'(here);
            if (c == CH_QUOTE) begin
               value_finish_q = offset_type'(here);
               phase = PH_STR_AFTER;
            end else begin
               phase = PH_STR;
            end
         end
         PH_STR: begin
            if (c == CH_QUOTE) begin
               value_finish_q = offset_type'(here);
               phase = PH_STR_AFTER;
            end
         end
         PH_NUM_INT: begin
            if (is_digit(c)) begin
            end else if (c == CH_DOT) begin
               phase = PH_NUM_FRAC;
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               phase = PH_NUM_EXP_SIGN;
            end else begin
               end_number(c, here);
            end
         end
         PH_NUM_FRAC: begin
            if (is_digit(c)) begin
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               phase = PH_NUM_EXP_SIGN;
            end else begin
               end_number(c, here);
            end
         end
         PH_NUM_EXP_SIGN: begin
            if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) phase = PH_NUM_EXP;
            else fail = 1'b1;
         end
         PH_NUM_EXP: begin
            if (!is_digit(c)) end_number(c, here);
         end
         PH_OBJECT, PH_ARRAY: begin
            opener = (phase == PH_OBJECT) ? CH_LBRACE : CH_LBRACKET;
            closer = (phase == PH_OBJECT) ? CH_RBRACE : CH_RBRACKET;
            if (c == opener) begin
               if (depth == DEPTH_TOP) fail = 1'b1;
               else depth++;
            end else if (c == closer) begin
               if (depth != 0) depth--;
               if (depth == 0) begin
                  value_finish_q = offset_type'(here);
                  phase = PH_AFTER_VALUE;
               end
            end
         end
         default: begin
            if (c == CH_COMMA) report_member(KIND_COMMA);
            else if (c == CH_RBRACE) report_member(KIND_CLOSE);
            else if (c != CH_SPACE) fail = 1'b1;
         end
      endcase
      if (fail) report_member(KIND_ERROR);
   endfunction

   function automatic void check_field(input string field,
                                       input logic [OFFSET_BITS-1:0] want,
                                       input logic [OFFSET_BITS-1:0] got);
      if (got !== want) begin
         fails++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      member_report_type want;
      member_report_type got;
      if (reset) begin
         phase = PH_START;
         position = '0;
         depth = '0;
         name_begin_q = '0;
         name_finish_q = '0;
         value_begin_q = '0;
         value_finish_q = '0;
         pending_members.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[0 +: OFFSET_BITS], rsp_tdata[OFFSET_BITS +: OFFSET_BITS],
                   rsp_tdata[2*OFFSET_BITS +: OFFSET_BITS],
                   rsp_tdata[3*OFFSET_BITS +: OFFSET_BITS]};
            if (pending_members.size() == 0) begin
               fails++;
               $display("%0t: result beat expected none actual kind %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pending_members.pop_front();
               check_field("result_kind", offset_type'(want.kind), offset_type'(got.kind));
               check_field("name_begin", want.name_begin, got.name_begin);
               check_field("name_finish", want.name_finish, got.name_finish);
               check_field("value_begin", want.value_begin, got.value_begin);
               check_field("value_finish", want.value_finish, got.value_finish);
            end
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata);
      end
      results_due <= pending_members.size();
      mismatches  <= fails;
   end

endmodule

### dv/json_object_member_splitter_test.sv
// testbench top for the json object member splitter: byte stimulus, result pacing, verdict
// depends on jsplit_pkg, json_object_member_splitter and json_object_member_splitter_checker
module json_object_member_splitter_test;
   import jsplit_pkg::*;

   localparam int RANDOM_BYTES = 1700;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_BITS-1:0]     req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0]     rsp_tuser;
   int unsigned              mismatches;
   int unsigned              results_due;

   int unsigned cycle_count = 0;
   int unsigned sent = 0;
   int          idle_odds = 0;
   bit          steady = 1'b0;
   bit          hold_rsp = 1'b0;
   byte_type    json_text[$];

   json_object_member_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   json_object_member_splitter_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side pacing
   initial begin
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic push_byte(input byte_type b);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_text();
      byte_type b;
      while (json_text.size() != 0) begin
         b = json_text.pop_front();
         if (!steady && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         push_byte(b);
      end
   endtask

   task automatic put(input byte_type b);
      json_text.push_back(b);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) json_text.push_back(s[i]);
   endtask

   task automatic put_spaces();
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) put(CH_SPACE);
   endtask

   task automatic put_digit();
      put(byte_type'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic put_name();
      byte_type b;
      repeat ($urandom_range(0, 5)) begin
         do b = byte_type'($urandom_range(32, 126));
         while (b == CH_QUOTE || b == CH_BACKSLASH);
         put(b);
      end
   endtask

   task automatic put_number();
      if ($urandom_range(0, 1)) put(CH_MINUS);
      repeat ($urandom_range(1, 4)) put_digit();
      if ($urandom_range(0, 1)) begin
         put(CH_DOT);
         repeat ($urandom_range(0, 3)) put_digit();
      end
      if ($urandom_range(0, 2) == 0) begin
         put($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
         case ($urandom_range(0, 2))
            0: begin
               put(CH_PLUS);
               repeat ($urandom_range(0, 3)) put_digit();
            end
            1: begin
               put(CH_MINUS);
               repeat ($urandom_range(0, 3)) put_digit();
            end
            default: repeat ($urandom_range(1, 3)) put_digit();
         endcase
      end
   endtask

   task automatic put_nested(input byte_type open_ch, input byte_type close_ch,
                             input int levels);
      byte_type b;
      put(open_ch);
      repeat ($urandom_range(0, 4)) begin
         if (levels > 0 && $urandom_range(0, 2) == 0) begin
            put_nested(open_ch, close_ch, levels - 1);
         end else begin
            do b = byte_type'($urandom_range(0, 255));
            while (b == open_ch || b == close_ch);
            put(b);
         end
      end
      put(close_ch);
   endtask

   task automatic put_value(output bit may_pad);
      byte_type b;
      may_pad = 1'b1;
      case ($urandom_range(0, 3))
         0: begin
            put(CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
               do b = byte_type'($urandom_range(0, 255));
               while (b == CH_QUOTE);
               put(b);
            end
            put(CH_QUOTE);
         end
         1: begin
            put_number();
            may_pad = 1'b0;
         end
         2: put_nested(CH_LBRACE, CH_RBRACE, $urandom_range(0, 3));
         default: put_nested(CH_LBRACKET, CH_RBRACKET, $urandom_range(0, 3));
      endcase
   endtask

   task automatic put_object();
      bit may_pad;
      put(CH_LBRACE);
      for (int m = $urandom_range(1, 4); m > 0; m--) begin
         put_spaces();
         put(CH_QUOTE);
         put_name();
         put(CH_QUOTE);
         put(CH_COLON);
         put_spaces();
         put_value(may_pad);
         if (may_pad) put_spaces();
         put(m == 1 ? CH_RBRACE : CH_COMMA);
      end
   endtask

   initial begin
      int unsigned random_start;
      int unsigned progress;
      int unsigned cut;
      bit          did_hold;
      bit          did_deep;
      bit          did_pause;
      did_hold  = 1'b0;
      did_deep  = 1'b0;
      did_pause = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      idle_odds = 4;
      put(8'hFF);
      put(8'h00);
      put_str("}{ \"\":\"\" ,\"n\":-0.5E-7}");
      put_str("{\"o\":{\"x\":[1]} ,\"r\":[[]] }");
      put_str("{\"k\" :");
      put_str("{\"s\":\"a\\\"}");
      put_str("{\"q\\");
      put_str("{\"");
      put(8'h01);
      put_str("{\"");
      put(CH_DEL);
      put_str("{\"e\":1e}{\"t\":7 }{\"u\":2.}{\"v\":x");
      send_text();

      random_start = sent;
      while (sent - random_start < RANDOM_BYTES) begin
         progress = sent - random_start;
         if (!did_hold && progress > RANDOM_BYTES / 4) begin
            did_hold = 1'b1;
            hold_rsp <= 1'b1;
         end
         if (!did_deep && progress > RANDOM_BYTES / 2) begin
            did_deep = 1'b1;
            // deepest legal nesting, then one level too many
            put_str("{\"d\":");
            repeat ((1 << DEPTH_BITS) - 1) put(CH_LBRACKET);
            repeat ((1 << DEPTH_BITS) - 1) put(CH_RBRACKET);
            put_str("}{\"d\":");
            repeat (1 << DEPTH_BITS) put(CH_LBRACE);
         end
         if (!did_pause && progress > RANDOM_BYTES * 5 / 8) begin
            did_pause = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (results_due != 0);
         end
         if (progress > RANDOM_BYTES * 7 / 8) steady = 1'b1;
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 3;
            default: idle_odds = 8;
         endcase
         case ($urandom_range(0, 19)) inside
            [0:13]: put_object();
            [14:16]: begin
               put_object();
               cut = $urandom_range(0, json_text.size() - 1);
               if ($urandom_range(0, 1)) begin
                  json_text[cut] = byte_type'($urandom_range(0, 255));
               end else begin
                  while (json_text.size() > cut + 1) void'(json_text.pop_back());
               end
            end
            default: repeat ($urandom_range(1, 6)) put(byte_type'($urandom_range(0, 255)));
         endcase
         send_text();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
